### hw/rtl/tfj_pkg.sv
// Shared types and constants for the trigger, fire and jam controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package tfj_pkg;

  // Operation codes carried by the op field
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_INIT = 1'b1;

  // Remote switch positions
  localparam logic [1:0] SW_DOWN = 2'd1;
  localparam logic [1:0] SW_MID  = 2'd3;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SHOT_STEP         = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WHEEL_SPEED       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEAT_CHECK_ENABLE = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEAT_MARGIN_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_JAM_ERROR_LIMIT   = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_JAM_SPEED_LIMIT   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_JAM_COUNT_LIMIT   = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BURST_HOLD_TICKS  = 3'd7;
  localparam int CFG_DATA_BITS = 18;

  // Counter saturation value
  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    STATUS_NORMAL   = 2'd0,
    STATUS_OVERHEAT = 2'd1,
    STATUS_JAM      = 2'd2,
    STATUS_INIT     = 2'd3
  } status_t;

  typedef struct packed {
    logic [17:0] shot_step;
    logic [13:0] wheel_speed;
    logic        heat_check_enable;
    logic [9:0]  heat_margin_limit;
    logic [17:0] jam_error_limit;
    logic [9:0]  jam_speed_limit;
    logic [7:0]  jam_count_limit;
    logic [7:0]  burst_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [1:0]  switch_pos;
    logic        mouse_left;
    logic        mouse_right;
    logic        vision_lock;
    logic [31:0] trigger_angle;
    logic [15:0] trigger_speed;
    logic [15:0] heat_limit;
    logic [15:0] barrel_heat;
  } item_t;

  typedef struct packed {
    logic [13:0] friction_target;
    logic [31:0] trigger_target;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/tfj_cfg_regs.sv
// Configuration register file for the trigger, fire and jam controller.
// Depends on tfj_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module tfj_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [tfj_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [tfj_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output tfj_pkg::cfg_t                           cfg
);
  import tfj_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shot_step         <= 18'd36864;
      cfg.wheel_speed       <= 14'd6300;
      cfg.heat_check_enable <= 1'b0;
      cfg.heat_margin_limit <= 10'd40;
      cfg.jam_error_limit   <= 18'd7372;
      cfg.jam_speed_limit   <= 10'd30;
      cfg.jam_count_limit   <= 8'd50;
      cfg.burst_hold_ticks  <= 8'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHOT_STEP:         cfg.shot_step         <= cfg_data;
        CFG_WHEEL_SPEED:       cfg.wheel_speed       <= cfg_data[13:0];
        CFG_HEAT_CHECK_ENABLE: cfg.heat_check_enable <= cfg_data[0];
        CFG_HEAT_MARGIN_LIMIT: cfg.heat_margin_limit <= cfg_data[9:0];
        CFG_JAM_ERROR_LIMIT:   cfg.jam_error_limit   <= cfg_data;
        CFG_JAM_SPEED_LIMIT:   cfg.jam_speed_limit   <= cfg_data[9:0];
        CFG_JAM_COUNT_LIMIT:   cfg.jam_count_limit   <= cfg_data[7:0];
        CFG_BURST_HOLD_TICKS:  cfg.burst_hold_ticks  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tfj_core.sv
// Controller state and single-pass next-state / result logic.
// Depends on tfj_pkg for item_t, result_t, cfg_t and the code constants.
`default_nettype none

module tfj_core #(
  parameter int ANGLE_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire tfj_pkg::item_t  item,
  input  wire tfj_pkg::cfg_t   cfg,
  output tfj_pkg::result_t     result
);
  import tfj_pkg::*;

  localparam int ERR_BITS = ANGLE_BITS + 1;
  localparam int DEC_BITS = ANGLE_BITS + 20;

  logic signed [ANGLE_BITS-1:0] feed_goal, feed_goal_next;
  logic [1:0]                   prev_switch, prev_switch_next;
  logic                         last_mouse_left, last_mouse_left_next;
  logic [7:0]                   hold_count, hold_count_next;
  logic [7:0]                   stall_count, stall_count_next;

  logic signed [ANGLE_BITS-1:0] meas;
  logic signed [ERR_BITS-1:0]   err, err_abs;
  logic signed [16:0]           speed_ext, speed_abs;
  logic signed [16:0]           heat_margin;
  logic                         overheat, stall, jam;
  logic [7:0]                   stall_inc, hold_inc, hold_new;
  logic                         shot, aim_shot;
  logic [DEC_BITS-1:0]          dec, target_ext;

  // Measured angle reduced to the target width (sign-extend or truncate)
  assign meas = ANGLE_BITS'(signed'(item.trigger_angle));

  assign err     = ERR_BITS'(feed_goal) - ERR_BITS'(meas);
  assign err_abs = err[ERR_BITS-1] ? -err : err;

  assign speed_ext = 17'(signed'(item.trigger_speed));
  assign speed_abs = speed_ext[16] ? -speed_ext : speed_ext;

  assign heat_margin = signed'({1'b0, item.heat_limit}) - signed'({1'b0, item.barrel_heat});
  assign overheat    = cfg.heat_check_enable &&
                       (heat_margin < signed'({7'b0, cfg.heat_margin_limit}));

  assign stall = (err_abs > signed'(ERR_BITS'(cfg.jam_error_limit))) &&
                 (speed_abs < signed'({7'b0, cfg.jam_speed_limit}));

  assign stall_inc = (stall_count == COUNT_MAX) ? stall_count : stall_count + 8'd1;
  assign hold_inc  = (hold_count == COUNT_MAX) ? hold_count : hold_count + 8'd1;

  // Press edge restarts the hold count at one; release clears it
  always_comb begin
    if (!item.mouse_left) begin
      hold_new = 8'd0;
    end else if (!last_mouse_left) begin
      hold_new = 8'd1;
    end else begin
      hold_new = hold_inc;
    end
  end

  assign shot = (item.switch_pos == SW_DOWN && prev_switch != SW_DOWN) ||
                (item.mouse_left && !last_mouse_left) ||
                (item.mouse_left && hold_new > cfg.burst_hold_ticks);
  assign aim_shot = item.mouse_right && item.vision_lock;

  always_comb begin
    if (shot && aim_shot) begin
      dec = DEC_BITS'({cfg.shot_step, 1'b0});
    end else if (shot || aim_shot) begin
      dec = DEC_BITS'(cfg.shot_step);
    end else begin
      dec = '0;
    end
  end
  assign target_ext = DEC_BITS'(feed_goal) - dec;

  assign jam = stall_inc > cfg.jam_count_limit;

  always_comb begin
    feed_goal_next       = feed_goal;
    prev_switch_next     = prev_switch;
    last_mouse_left_next = last_mouse_left;
    hold_count_next      = hold_count;
    stall_count_next     = stall_count;
    result.friction_target = cfg.wheel_speed;
    result.status          = STATUS_NORMAL;
    if (item.op == OP_INIT) begin
      feed_goal_next       = meas;
      prev_switch_next     = SW_MID;
      last_mouse_left_next = 1'b0;
      hold_count_next      = 8'd0;
      stall_count_next     = 8'd0;
      result.friction_target = 14'd0;
      result.status          = STATUS_INIT;
    end else if (overheat) begin
      result.friction_target = 14'd0;
      result.status          = STATUS_OVERHEAT;
    end else begin
      stall_count_next = stall ? stall_inc : 8'd0;
      if (stall && jam) begin
        feed_goal_next = meas;
        result.status  = STATUS_JAM;
      end else begin
        prev_switch_next     = item.switch_pos;
        last_mouse_left_next = item.mouse_left;
        hold_count_next      = hold_new;
        feed_goal_next       = signed'(target_ext[ANGLE_BITS-1:0]);
      end
    end
    result.trigger_target = 32'(feed_goal_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      feed_goal       <= '0;
      prev_switch     <= SW_MID;
      last_mouse_left <= 1'b0;
      hold_count      <= 8'd0;
      stall_count     <= 8'd0;
    end else if (fire) begin
      feed_goal       <= feed_goal_next;
      prev_switch     <= prev_switch_next;
      last_mouse_left <= last_mouse_left_next;
      hold_count      <= hold_count_next;
      stall_count     <= stall_count_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/trigger_fire_jam_controller.sv
// Trigger, fire and jam controller: input register, single-pass core, result register.
// Throughput 1 item per cycle while the result channel is not stalled; the result is registered,
// passing from the input register through the single-pass core into the result register.
// Reset (rst, synchronous, active high) restores the register defaults, sets the
// target angle to zero, the last switch to middle and clears counters and valid flags.
// Depends on tfj_pkg, tfj_cfg_regs and tfj_core.
`default_nettype none

module trigger_fire_jam_controller #(
  parameter int ANGLE_BITS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Input channel
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               op,
  input  wire logic [1:0]                         switch_pos,
  input  wire logic                               mouse_left,
  input  wire logic                               mouse_right,
  input  wire logic                               vision_lock,
  input  wire logic signed [31:0]                 trigger_angle,
  input  wire logic signed [15:0]                 trigger_speed,
  input  wire logic [15:0]                        heat_limit,
  input  wire logic [15:0]                        barrel_heat,
  // Result channel
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [13:0]                             friction_target,
  output logic signed [31:0]                      trigger_target,
  output logic [1:0]                              status,
  // Configuration write port
  input  wire logic                               cfg_we,
  input  wire logic [tfj_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [tfj_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import tfj_pkg::*;

  cfg_t    cfg;
  item_t   stage_item;
  logic    stage_valid;
  result_t core_result;
  logic    advance;
  logic    fire;
  logic    in_xfer;

  tfj_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The result register advances when empty or when its transfer completes;
  // the staged item fires into the core and updates the state on that edge.
  assign advance  = !out_valid || out_ready;
  assign fire     = stage_valid && advance;
  assign in_ready = !stage_valid || advance;
  assign in_xfer  = in_valid && in_ready;

  // Input register: valid flag under reset, payload only loads on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_xfer) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stage_item.op             <= op;
      stage_item.switch_pos     <= switch_pos;
      stage_item.mouse_left     <= mouse_left;
      stage_item.mouse_right    <= mouse_right;
      stage_item.vision_lock    <= vision_lock;
      stage_item.trigger_angle  <= trigger_angle;
      stage_item.trigger_speed  <= trigger_speed;
      stage_item.heat_limit     <= heat_limit;
      stage_item.barrel_heat    <= barrel_heat;
    end
  end

  tfj_core #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (stage_item),
    .cfg    (cfg),
    .result (core_result)
  );

  // Result register: hold while the downstream side stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      friction_target <= core_result.friction_target;
      trigger_target  <= signed'(core_result.trigger_target);
      status          <= core_result.status;
    end
  end

endmodule

`default_nettype wire
